// ===== design/lscc_pkg.sv =====
// ----------------------------------------------------------------------------
// lscc_pkg: shared types and constants of the context classifier
// Weights, biases, tone levels and the exp step table.
// ----------------------------------------------------------------------------
`default_nettype none
package lscc_pkg;

	localparam int NUM_FEATURES_DEF = 16;
	localparam int NUM_CLASSES      = 6;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int USED_FEATURES    = 10;
	localparam int EXP_BITS         = 16;
	localparam int LOGIT_W          = 36;

	typedef logic signed [15:0]      feat_t;
	typedef logic signed [LOGIT_W-1:0] logit_t;
	typedef logic [2:0]              class_t;

	function automatic logic signed [13:0] weight(input int c, input int i);
		logic signed [13:0] w [NUM_CLASSES][USED_FEATURES];
		w[0] = '{14'sd3277, 14'sd3686, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0,
			-14'sd2048, 14'sd0, 14'sd0};
		w[1] = '{-14'sd1229, -14'sd2867, 14'sd0, 14'sd0, 14'sd1638, 14'sd0, 14'sd0,
			14'sd0, 14'sd0, 14'sd0};
		w[2] = '{14'sd0, 14'sd0, 14'sd3686, -14'sd1229, 14'sd0, 14'sd0, 14'sd3277,
			14'sd0, 14'sd0, 14'sd0};
		w[3] = '{14'sd0, 14'sd0, 14'sd0, 14'sd3686, 14'sd2867, 14'sd2458, 14'sd0,
			14'sd0, 14'sd0, 14'sd0};
		w[4] = '{14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd3686,
			14'sd3277, 14'sd2867, 14'sd0};
		w[5] = '{14'sd1638, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd2458,
			14'sd0, 14'sd0, 14'sd2048};
		return w[c][i];
	endfunction

	function automatic logit_t bias(input int c);
		logic signed [12:0] b [NUM_CLASSES];
		b = '{13'sd819, -13'sd410, 13'sd1229, 13'sd410, 13'sd1638, 13'sd0};
		return logit_t'(b[c]) <<< 12;
	endfunction

	// formality, precision, emotional tone, urgency
	function automatic logic [63:0] levels(input class_t c);
		case (c)
			3'd0: return {16'sd14746, 16'sd13107, 16'sd0, 16'sd4915};
			3'd1: return {16'sd3277, 16'sd8192, 16'sd4915, 16'sd1638};
			3'd2: return {16'sd11469, 16'sd15565, 16'sd0, 16'sd3277};
			3'd3: return {16'sd4915, 16'sd6554, 16'sd13107, 16'sd6554};
			3'd4: return {16'sd8192, 16'sd14746, -16'sd3277, 16'sd15565};
			3'd5: return {16'sd8192, 16'sd11469, 16'sd3277, 16'sd0};
			default: return '0;
		endcase
	endfunction

	function automatic logic [24:0] exp_step(input logic [3:0] k);
		case (k)
			4'd0: return 25'd16773120;  4'd1: return 25'd16769026;
			4'd2: return 25'd16760840;  4'd3: return 25'd16744480;
			4'd4: return 25'd16711808;  4'd5: return 25'd16646655;
			4'd6: return 25'd16517109;  4'd7: return 25'd16261035;
			4'd8: return 25'd15760736;  4'd9: return 25'd14805841;
			4'd10: return 25'd13066109; 4'd11: return 25'd10175896;
			4'd12: return 25'd6171993;  4'd13: return 25'd2270549;
			4'd14: return 25'd307285;   default: return 25'd5628;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== design/lscc_exp_lane.sv =====
// ----------------------------------------------------------------------------
// lscc_exp_lane: one exp(-d) lane
// Walks the 16 bits of the rounded distance, one multiply per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lscc_exp_lane
	import lscc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [LOGIT_W-1:0] delta,
	output logic              done,
	output logic [24:0]       e_val
);
	logic [LOGIT_W-1:0]  d_rnd;
	logic [LOGIT_W-13:0] dq_full;
	logic [15:0] dq_q;
	logic [3:0]  k_q;
	logic        busy_q;
	logic [49:0] prod;

	// round the Q24 distance to Q12
	assign d_rnd   = delta + LOGIT_W'(2048);
	assign dq_full = d_rnd[LOGIT_W-1:12];
	assign prod = 50'(e_val) * 50'(exp_step(k_q)) + 50'(1 << 23);

	// bit-serial product of table steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			k_q    <= '0;
			dq_q   <= '0;
			e_val  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				dq_q   <= dq_full[15:0];
				e_val  <= (dq_full[LOGIT_W-13:16] != '0) ? 25'd0 : 25'd1 << 24;
			end else if (busy_q) begin
				if (dq_q[k_q]) e_val <= prod[48:24];
				k_q <= k_q + 4'd1;
				if (k_q == 4'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/lscc_divider.sv =====
// ----------------------------------------------------------------------------
// lscc_divider: restoring divider for the confidence
// One quotient bit per cycle of (65535*2^24 + S/2) / S.
// ----------------------------------------------------------------------------
`default_nettype none
module lscc_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [27:0] divisor,
	output logic             done,
	output logic [15:0]      quotient
);
	localparam int NW = 41;
	logic [NW-1:0] num_q;
	logic [28:0]   rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [28:0]   trial;
	logic [NW-1:0] qacc_q;

	assign trial = {rem_q[27:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			qacc_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= NW'(64'd65535 << 24) + NW'(divisor >> 1);
				rem_q  <= '0;
				cnt_q  <= '0;
				qacc_q <= '0;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (trial >= {1'b0, divisor}) begin
					rem_q  <= trial - {1'b0, divisor};
					qacc_q <= {qacc_q[NW-2:0], 1'b1};
				end else begin
					rem_q  <= trial;
					qacc_q <= {qacc_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign quotient = qacc_q[15:0];
endmodule
`default_nettype wire

// ===== design/linear_softmax_context_classifier_top.sv =====
// ----------------------------------------------------------------------------
// linear_softmax_context_classifier_top: six-class classifier with confidence
// Six logit lanes, argmax merge, six exp lanes, divider and counters.
// ----------------------------------------------------------------------------
// From input beat to result valid: logit, argmax, lane load, exp steps, sum,
// divider load, divider steps, output.
// One item at a time; a new beat is taken only in idle, after the result is accepted.
// A zero-count item skips the classifier; its result valid is registered from its beat.
// Reset clears counters, control and output registers.
`default_nettype none
module linear_softmax_context_classifier_top
	import lscc_pkg::*;
#(
	parameter int NUM_FEATURES = NUM_FEATURES_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [4:0] feature_count,
	input  wire logic signed [15:0] feat_complexity,
	input  wire logic signed [15:0] feat_formality,
	input  wire logic signed [15:0] feat_technical,
	input  wire logic signed [15:0] feat_emotion,
	input  wire logic signed [15:0] feat_sentiment,
	input  wire logic signed [15:0] feat_arousal,
	input  wire logic signed [15:0] feat_precision,
	input  wire logic signed [15:0] feat_pressure,
	input  wire logic signed [15:0] feat_priority,
	input  wire logic signed [15:0] feat_explanatory,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic bad_request,
	output logic [2:0] context_class,
	output logic [15:0] confidence,
	output logic signed [15:0] formal_lvl,
	output logic signed [15:0] precise_lvl,
	output logic signed [15:0] emotion_lvl,
	output logic signed [15:0] urgent_lvl,
	output logic [31:0] detect_total,
	output logic [31:0] class_detections
);
	typedef enum logic [2:0] {ST_IDLE, ST_LOGIT, ST_EXP, ST_SUM, ST_DIV, ST_OUT} state_t;
	state_t state_q;

	feat_t  feat_q [USED_FEATURES];
	logit_t logit_q [NUM_CLASSES];
	logit_t lmax_q;
	class_t best_q;
	logic   exp_start_q, div_start_q;
	logic [NUM_CLASSES-1:0] exp_done;
	logic [24:0] e_val [NUM_CLASSES];
	logic [27:0] sum_q;
	logic        div_done;
	logic [15:0] quot;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] total_nx, cls_nx;
	logit_t lane_sum [NUM_CLASSES];
	logit_t mx;
	class_t bi;
	logic [27:0] esum;

	// feature vector, masked when it is registered
	feat_t fin [USED_FEATURES];
	assign fin = '{feat_complexity, feat_formality, feat_technical, feat_emotion,
		feat_sentiment, feat_arousal, feat_precision, feat_pressure, feat_priority,
		feat_explanatory};

	// logit lanes
	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			lane_sum[c] = bias(c);
			for (int i = 0; i < USED_FEATURES; i++)
				lane_sum[c] = lane_sum[c] + logit_t'(weight(c, i)) * logit_t'(feat_q[i]);
		end
	end

	// argmax merge, lowest index on ties
	always_comb begin
		mx = logit_q[0];
		bi = '0;
		for (int c = 1; c < NUM_CLASSES; c++)
			if (logit_q[c] > mx) begin
				mx = logit_q[c];
				bi = class_t'(c);
			end
	end

	always_comb begin
		esum = '0;
		for (int c = 0; c < NUM_CLASSES; c++) esum = esum + 28'(e_val[c]);
	end

	// next counter values, wrapping at the counter width
	assign total_nx = total_q + COUNT_WIDTH'(1);
	assign cls_nx   = cnt_q[best_q] + COUNT_WIDTH'(1);

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_exp
		lscc_exp_lane u_exp (
			.clk(clk), .arst_n(arst_n), .start(exp_start_q),
			.delta(LOGIT_W'(lmax_q - logit_q[g])),
			.done(exp_done[g]), .e_val(e_val[g])
		);
	end

	lscc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.divisor(sum_q), .done(div_done), .quotient(quot)
	);

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			exp_start_q <= 1'b0;
			div_start_q <= 1'b0;
			total_q     <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) cnt_q[c] <= '0;
			for (int i = 0; i < USED_FEATURES; i++) feat_q[i] <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) logit_q[c] <= '0;
			lmax_q <= '0;
			best_q <= '0;
			sum_q  <= '0;
			bad_request <= 1'b0;
			context_class <= '0; confidence <= '0;
			formal_lvl <= '0; precise_lvl <= '0;
			emotion_lvl <= '0; urgent_lvl <= '0;
			detect_total <= '0; class_detections <= '0;
		end else begin
			exp_start_q <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					for (int i = 0; i < USED_FEATURES; i++)
						feat_q[i] <= (5'(i) < feature_count && i < NUM_FEATURES) ?
							fin[i] : '0;
					if (feature_count == '0) begin
						bad_request <= 1'b1;
						context_class <= '0; confidence <= '0;
						formal_lvl <= '0; precise_lvl <= '0;
						emotion_lvl <= '0; urgent_lvl <= '0;
						detect_total <= '0; class_detections <= '0;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else state_q <= ST_LOGIT;
				end
				ST_LOGIT: begin
					for (int c = 0; c < NUM_CLASSES; c++) logit_q[c] <= lane_sum[c];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// merge stage; launch exp lanes
					lmax_q <= mx;
					best_q <= bi;
					exp_start_q <= 1'b1;
					state_q <= ST_EXP;
				end
				ST_EXP: if (&exp_done) begin
					sum_q <= esum;
					div_start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: if (div_done) begin
					bad_request <= 1'b0;
					context_class <= best_q;
					confidence <= quot;
					{formal_lvl, precise_lvl, emotion_lvl, urgent_lvl}
						<= levels(best_q);
					total_q <= total_nx;
					cnt_q[best_q] <= cls_nx;
					detect_total <= 32'(64'(total_nx));
					class_detections <= 32'(64'(cls_nx));
					out_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
